// File: rtl/core/lj_pkg.sv
// Shared types, constants and fixed-point helpers for the Lennard-Jones pair block.
// No dependencies; imported by lennard_jones_pair_forces.
package lj_pkg;

   localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

   localparam logic [7:0] REG_CUTOFF  = 8'd0;
   localparam logic [7:0] REG_SIGMA   = 8'd1;
   localparam logic [7:0] REG_EPSILON = 8'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_START, S_START2, S_START3, S_CLR,
      S_MUL, S_DIV,
      S_RDI, S_RDJ, S_DIFF, S_SQ, S_SQACC, S_CUT,
      S_U, S_L2, S_L6, S_L12, S_P12, S_P6, S_A, S_B, S_EACC,
      S_QDIV, S_QMUL, S_GCOMP,
      S_ACCRD, S_ACCWI, S_ACCWJ, S_NEXT,
      S_OUTRD, S_OUTLD, S_OUTHOLD
   } state_type;

   // Saturating signed add; bit 64 of the result is the saturation flag.
   function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return {1'b1, (s[64] ? SMIN : SMAX)};
      end
      return {1'b0, s[63:0]};
   endfunction

   // Unsigned Q32.32 product with saturation; bit 64 is the flag.
   function automatic logic [64:0] mulq(input logic [127:0] p);
      if (|p[127:96]) begin
         return {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
      end
      return {1'b0, p[95:32]};
   endfunction

   function automatic logic [64:0] clamp30(input logic [127:0] p);
      if (|p[127:93]) begin
         return {1'b1, SMAX};
      end
      return {1'b0, 1'b0, p[92:30]};
   endfunction

   function automatic logic [64:0] clamp32(input logic [127:0] p);
      if (|p[127:95]) begin
         return {1'b1, SMAX};
      end
      return {1'b0, 1'b0, p[94:32]};
   endfunction

endpackage

// File: rtl/core/lj_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module lj_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// File: rtl/core/lennard_jones_pair_forces.sv
// Lennard-Jones 12-6 pair energy and gradients with cutoff, fixed point.
// Each atom is stored as it is accepted; the last atom starts setup and clearing, then
// works through every pair within the cutoff (pairs beyond it are skipped early) on the
// shared divider and the shared 64x64 multiplier, then gives one result beat per atom.
// Reset (synchronous, active high) restores the register defaults and empties the
// atom count; position and gradient memories are not cleared.
module lennard_jones_pair_forces #(
   parameter int MAX_ATOMS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic               req_last_atom,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_atom_index,
   output logic signed [63:0] rsp_grad_x,
   output logic signed [63:0] rsp_grad_y,
   output logic signed [63:0] rsp_grad_z,
   output logic signed [63:0] rsp_total_energy,
   output logic               rsp_flagged,
   output logic               rsp_last_result,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import lj_pkg::*;

   localparam int AW = $clog2(MAX_ATOMS);
   localparam int CW = $clog2(MAX_ATOMS + 1);

   // Configuration registers.
   logic [31:0] cutoff_ff, sigma_ff, eps_ff;

   // Control state.
   state_type state_ff, state_in, mret_ff, mret_in, dret_ff, dret_in;
   logic [CW-1:0] count_ff, count_in;
   logic err_ff, err_in, fl_ff, fl_in, huge_ff, huge_in, dsat_ff, dsat_in;
   logic [AW-1:0] i_ff, i_in, j_ff, j_in;
   logic [1:0] c_ff, c_in;
   logic rsp_valid_ff, rsp_valid_in;

   // Shared multiplier: 64x64 product built from four 32x32 partial products.
   logic [63:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic [127:0] prod_ff, prod_in;
   logic [1:0]   mcnt_ff, mcnt_in;
   logic [31:0]  pa, pb;
   logic [63:0]  pp;
   logic [127:0] pp_sh;

   // Shared divider: restoring, one quotient bit per cycle.
   logic [63:0] dr_ff, dr_in, dlo_ff, dlo_in, dd_ff, dd_in, dq_ff, dq_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [63:0] dr2, ddiff;
   logic        dtake;

   // Per-pair datapath registers.
   logic [31:0] pi_ff [3];
   logic [31:0] pi_in [3];
   logic [31:0] mag_ff [3];
   logic [31:0] mag_in [3];
   logic        neg_ff [3];
   logic        neg_in [3];
   logic [63:0] g_ff [3];
   logic [63:0] g_in [3];
   logic [63:0] d2_ff, d2_in, cut2_ff, cut2_in, s2_ff, s2_in;
   logic [63:0] u_ff, u_in, l6_ff, l6_in, l12_ff, l12_in;
   logic [63:0] p12_ff, p12_in, p6_ff, p6_in, fa_ff, fa_in;
   logic [63:0] eterm_ff, eterm_in, p_ff, p_in, energy_ff, energy_in;
   logic        s12_ff, s12_in, sa_ff, sa_in;

   // Output registers.
   logic [5:0]  o_idx_ff, o_idx_in;
   logic [63:0] o_gx_ff, o_gx_in, o_gy_ff, o_gy_in, o_gz_ff, o_gz_in;
   logic        o_last_ff, o_last_in;

   // Memory ports.
   logic          pos_we;
   logic [AW-1:0] pos_waddr, pos_raddr;
   logic [31:0]   pos_wdata [3];
   logic [31:0]   pos_rdata [3];
   logic          acc_we;
   logic [AW-1:0] acc_waddr, acc_raddr;
   logic [63:0]   acc_wdata [3];
   logic [63:0]   acc_rdata [3];

   // Helpers.
   logic [37:0]  eps48;
   logic [36:0]  eps24;
   logic [64:0]  fn;
   logic [64:0]  sa0, sa1, sa2;
   logic [32:0]  diff [3];
   logic [64:0]  sqsum;
   logic [63:0]  pm;
   logic [31:0]  idx32;
   logic         accept, i_last, clr_last, j_more;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign eps48     = {eps_ff, 5'b0} + {1'b0, eps_ff, 4'b0};
   assign eps24     = {eps_ff, 4'b0} + {1'b0, eps_ff, 3'b0};
   assign pm        = p_ff[63] ? (64'd0 - p_ff) : p_ff;
   assign i_last    = (CW'(i_ff) + CW'(1)) == count_ff;
   assign clr_last  = i_last;
   assign j_more    = ({1'b0, j_ff} + (AW+1)'(1)) < {1'b0, i_ff};
   assign idx32     = 32'(i_ff);

   // Multiplier partial product for the current step.
   assign pa    = mcnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign pb    = mcnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign pp    = 64'(pa) * 64'(pb);
   assign pp_sh = (mcnt_ff == 2'd0) ? {64'd0, pp} :
                  (mcnt_ff == 2'd3) ? {pp, 64'd0} : {32'd0, pp, 32'd0};

   // Divider step.
   assign dr2   = {dr_ff[62:0], dlo_ff[63]};
   assign dtake = dr_ff[63] || (dr2 >= dd_ff);
   assign ddiff = dr2 - dd_ff;

   // Memories: three position stores and three gradient accumulators.
   for (genvar c = 0; c < 3; c++) begin : g_mem
      lj_ram #(.WIDTH(32), .DEPTH(MAX_ATOMS)) u_pos (
         .clock(clock), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata[c]),
         .raddr(pos_raddr), .rdata(pos_rdata[c])
      );
      lj_ram #(.WIDTH(64), .DEPTH(MAX_ATOMS)) u_acc (
         .clock(clock), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata[c]),
         .raddr(acc_raddr), .rdata(acc_rdata[c])
      );
      assign diff[c] = {pi_ff[c][31], pi_ff[c]} - {pos_rdata[c][31], pos_rdata[c]};
   end

   assign pos_wdata[0] = req_pos_x;
   assign pos_wdata[1] = req_pos_y;
   assign pos_wdata[2] = req_pos_z;
   assign pos_we       = accept && (count_ff < CW'(MAX_ATOMS));
   assign pos_waddr    = count_ff[AW-1:0];
   assign pos_raddr    = (state_ff == S_RDI) ? i_ff : j_ff;

   assign sqsum = {1'b0, d2_ff} + {1'b0, prod_ff[63:0]};

   // Configuration writes; only taken while the block is idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= 32'd655360;
         sigma_ff  <= 32'd65536;
         eps_ff    <= 32'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CUTOFF:  cutoff_ff <= csr_wdata;
            REG_SIGMA:   sigma_ff  <= csr_wdata;
            REG_EPSILON: eps_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mret_ff <= mret_in;   dret_ff <= dret_in;
      fl_ff <= fl_in;       huge_ff <= huge_in;   dsat_ff <= dsat_in;
      i_ff <= i_in;         j_ff <= j_in;         c_ff <= c_in;
      ma_ff <= ma_in;       mb_ff <= mb_in;       prod_ff <= prod_in;  mcnt_ff <= mcnt_in;
      dr_ff <= dr_in;       dlo_ff <= dlo_in;     dd_ff <= dd_in;
      dq_ff <= dq_in;       dcnt_ff <= dcnt_in;
      pi_ff <= pi_in;       mag_ff <= mag_in;     neg_ff <= neg_in;    g_ff <= g_in;
      d2_ff <= d2_in;       cut2_ff <= cut2_in;   s2_ff <= s2_in;
      u_ff <= u_in;         l6_ff <= l6_in;       l12_ff <= l12_in;
      p12_ff <= p12_in;     p6_ff <= p6_in;       fa_ff <= fa_in;
      eterm_ff <= eterm_in; p_ff <= p_in;         energy_ff <= energy_in;
      s12_ff <= s12_in;     sa_ff <= sa_in;
      o_idx_ff <= o_idx_in; o_gx_ff <= o_gx_in;   o_gy_ff <= o_gy_in;
      o_gz_ff <= o_gz_in;   o_last_ff <= o_last_in;
   end

   // Sequencer. Multiplies and divides are launched by loading the unit's
   // operands and a return state; the unit hands control back when done.
   always_comb begin
      state_in = state_ff;   mret_in = mret_ff;   dret_in = dret_ff;
      count_in = count_ff;   err_in = err_ff;     fl_in = fl_ff;
      huge_in = huge_ff;     dsat_in = dsat_ff;
      i_in = i_ff;           j_in = j_ff;         c_in = c_ff;
      ma_in = ma_ff;         mb_in = mb_ff;       prod_in = prod_ff;   mcnt_in = mcnt_ff;
      dr_in = dr_ff;         dlo_in = dlo_ff;     dd_in = dd_ff;
      dq_in = dq_ff;         dcnt_in = dcnt_ff;
      pi_in = pi_ff;         mag_in = mag_ff;     neg_in = neg_ff;     g_in = g_ff;
      d2_in = d2_ff;         cut2_in = cut2_ff;   s2_in = s2_ff;
      u_in = u_ff;           l6_in = l6_ff;       l12_in = l12_ff;
      p12_in = p12_ff;       p6_in = p6_ff;       fa_in = fa_ff;
      eterm_in = eterm_ff;   p_in = p_ff;         energy_in = energy_ff;
      s12_in = s12_ff;       sa_in = sa_ff;
      o_idx_in = o_idx_ff;   o_gx_in = o_gx_ff;   o_gy_in = o_gy_ff;
      o_gz_in = o_gz_ff;     o_last_in = o_last_ff;
      rsp_valid_in = rsp_valid_ff;
      acc_we = 1'b0;
      acc_waddr = i_ff;
      acc_raddr = i_ff;
      acc_wdata[0] = '0;     acc_wdata[1] = '0;   acc_wdata[2] = '0;
      fn = '0;  sa0 = '0;  sa1 = '0;  sa2 = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (count_ff < CW'(MAX_ATOMS)) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  err_in = 1'b1;
               end
               if (req_last_atom) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            fl_in     = err_ff;
            energy_in = '0;
            ma_in = 64'(cutoff_ff);  mb_in = 64'(cutoff_ff);
            prod_in = '0;  mcnt_in = '0;  mret_in = S_START2;  state_in = S_MUL;
         end
         S_START2: begin
            cut2_in = prod_ff[63:0];
            ma_in = 64'(sigma_ff);  mb_in = 64'(sigma_ff);
            prod_in = '0;  mcnt_in = '0;  mret_in = S_START3;  state_in = S_MUL;
         end
         S_START3: begin
            s2_in    = prod_ff[63:0];
            i_in     = '0;
            state_in = S_CLR;
         end
         S_CLR: begin
            // Clear the gradient accumulators of the stored atoms.
            acc_we = 1'b1;
            if (clr_last) begin
               i_in = AW'(1);
               j_in = '0;
               state_in = (count_ff < CW'(2)) ? S_OUTRD : S_RDI;
               if (count_ff < CW'(2)) begin
                  i_in = '0;
               end
            end else begin
               i_in = i_ff + AW'(1);
            end
         end
         S_MUL: begin
            prod_in = prod_ff + pp_sh;
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd3) begin
               state_in = mret_ff;
            end
         end
         S_DIV: begin
            dr_in   = dtake ? ddiff : dr2;
            dq_in   = {dq_ff[62:0], dtake};
            dlo_in  = {dlo_ff[62:0], 1'b0};
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd63) begin
               state_in = dret_ff;
            end
         end
         S_RDI: begin
            state_in = S_RDJ;
         end
         S_RDJ: begin
            pi_in    = pos_rdata;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            for (int c = 0; c < 3; c++) begin
               neg_in[c] = diff[c][32];
               mag_in[c] = diff[c][32] ? 32'(33'd0 - diff[c]) : diff[c][31:0];
            end
            d2_in    = '0;
            huge_in  = 1'b0;
            c_in     = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            ma_in = 64'(mag_ff[c_ff]);  mb_in = 64'(mag_ff[c_ff]);
            prod_in = '0;  mcnt_in = '0;  mret_in = S_SQACC;  state_in = S_MUL;
         end
         S_SQACC: begin
            d2_in = sqsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sqsum[63:0];
            c_in  = c_ff + 2'd1;
            state_in = (c_ff == 2'd2) ? S_CUT : S_SQ;
         end
         S_CUT: begin
            if (!(d2_ff < cut2_ff)) begin
               state_in = S_NEXT;
            end else if (d2_ff == 64'd0) begin
               fl_in    = 1'b1;
               state_in = S_NEXT;
            end else begin
               // u = sigma^2 / d2 in Q32.32.
               dd_in = d2_ff;  dcnt_in = '0;  dq_in = '0;  dret_in = S_U;
               dr_in = {32'd0, s2_ff[63:32]};  dlo_in = {s2_ff[31:0], 32'd0};
               if ({32'd0, s2_ff[63:32]} >= d2_ff) begin
                  dsat_in = 1'b1;  dq_in = '1;  state_in = S_U;
               end else begin
                  dsat_in = 1'b0;  state_in = S_DIV;
               end
            end
         end
         S_U: begin
            u_in    = dq_ff;
            huge_in = huge_ff | dsat_ff;
            ma_in = dq_ff;  mb_in = dq_ff;
            prod_in = '0;  mcnt_in = '0;  mret_in = S_L2;  state_in = S_MUL;
         end
         S_L2: begin
            fn = mulq(prod_ff);
            huge_in = huge_ff | fn[64];
            ma_in = fn[63:0];  mb_in = u_ff;
            prod_in = '0;  mcnt_in = '0;  mret_in = S_L6;  state_in = S_MUL;
         end
         S_L6: begin
            fn = mulq(prod_ff);
            huge_in = huge_ff | fn[64];
            l6_in = fn[63:0];
            ma_in = fn[63:0];  mb_in = fn[63:0];
            prod_in = '0;  mcnt_in = '0;  mret_in = S_L12;  state_in = S_MUL;
         end
         S_L12: begin
            fn = mulq(prod_ff);
            huge_in = huge_ff | fn[64];
            l12_in = fn[63:0];
            ma_in = 64'(eps_ff);  mb_in = fn[63:0];
            prod_in = '0;  mcnt_in = '0;  mret_in = S_P12;  state_in = S_MUL;
         end
         S_P12: begin
            fn = clamp30(prod_ff);
            p12_in = fn[63:0];  s12_in = fn[64];
            ma_in = 64'(eps_ff);  mb_in = l6_ff;
            prod_in = '0;  mcnt_in = '0;  mret_in = S_P6;  state_in = S_MUL;
         end
         S_P6: begin
            fn = clamp30(prod_ff);
            p6_in = fn[63:0];
            fl_in = fl_ff | (fn[64] && !(huge_ff && eps_ff != 32'd0));
            ma_in = 64'(eps48);  mb_in = l12_ff;
            prod_in = '0;  mcnt_in = '0;  mret_in = S_A;  state_in = S_MUL;
         end
         S_A: begin
            fn = clamp32(prod_ff);
            fa_in = fn[63:0];  sa_in = fn[64];
            ma_in = 64'(eps24);  mb_in = l6_ff;
            prod_in = '0;  mcnt_in = '0;  mret_in = S_B;  state_in = S_MUL;
         end
         S_B: begin
            fn = clamp32(prod_ff);
            if (huge_ff && eps_ff != 32'd0) begin
               // A pair too close to represent: both terms pinned to the maximum.
               fl_in    = 1'b1;
               eterm_in = SMAX;
               p_in     = SMAX;
            end else begin
               fl_in    = fl_ff | fn[64] | s12_ff | sa_ff;
               eterm_in = s12_ff ? SMAX : (p12_ff - p6_ff);
               p_in     = sa_ff ? SMAX : (fa_ff - fn[63:0]);
            end
            state_in = S_EACC;
         end
         S_EACC: begin
            fn = sat_add(energy_ff, eterm_ff);
            energy_in = fn[63:0];
            fl_in     = fl_ff | fn[64];
            c_in      = '0;
            state_in  = S_QDIV;
         end
         S_QDIV: begin
            // q = r_c / d2 in Q32.32.
            dd_in = d2_ff;  dcnt_in = '0;  dq_in = '0;  dret_in = S_QMUL;
            dr_in  = {48'd0, mag_ff[c_ff][31:16]};
            dlo_in = {mag_ff[c_ff][15:0], 48'd0};
            if ({48'd0, mag_ff[c_ff][31:16]} >= d2_ff) begin
               dq_in = '1;  state_in = S_QMUL;
            end else begin
               state_in = S_DIV;
            end
         end
         S_QMUL: begin
            ma_in = pm;  mb_in = dq_ff;
            prod_in = '0;  mcnt_in = '0;  mret_in = S_GCOMP;  state_in = S_MUL;
         end
         S_GCOMP: begin
            fn = clamp32(prod_ff);
            fl_in = fl_ff | fn[64];
            g_in[c_ff] = (p_ff[63] != neg_ff[c_ff]) ? fn[63:0] : (64'd0 - fn[63:0]);
            c_in = c_ff + 2'd1;
            state_in = (c_ff == 2'd2) ? S_ACCRD : S_QDIV;
         end
         S_ACCRD: begin
            acc_raddr = i_ff;
            state_in  = S_ACCWI;
         end
         S_ACCWI: begin
            sa0 = sat_add(acc_rdata[0], g_ff[0]);
            sa1 = sat_add(acc_rdata[1], g_ff[1]);
            sa2 = sat_add(acc_rdata[2], g_ff[2]);
            acc_we = 1'b1;  acc_waddr = i_ff;
            acc_wdata[0] = sa0[63:0];  acc_wdata[1] = sa1[63:0];  acc_wdata[2] = sa2[63:0];
            fl_in = fl_ff | sa0[64] | sa1[64] | sa2[64];
            acc_raddr = j_ff;
            state_in  = S_ACCWJ;
         end
         S_ACCWJ: begin
            sa0 = sat_add(acc_rdata[0], 64'd0 - g_ff[0]);
            sa1 = sat_add(acc_rdata[1], 64'd0 - g_ff[1]);
            sa2 = sat_add(acc_rdata[2], 64'd0 - g_ff[2]);
            acc_we = 1'b1;  acc_waddr = j_ff;
            acc_wdata[0] = sa0[63:0];  acc_wdata[1] = sa1[63:0];  acc_wdata[2] = sa2[63:0];
            fl_in = fl_ff | sa0[64] | sa1[64] | sa2[64];
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (j_more) begin
               j_in = j_ff + AW'(1);
               state_in = S_RDI;
            end else if (i_last) begin
               i_in = '0;
               state_in = S_OUTRD;
            end else begin
               i_in = i_ff + AW'(1);
               j_in = '0;
               state_in = S_RDI;
            end
         end
         S_OUTRD: begin
            acc_raddr = i_ff;
            state_in  = S_OUTLD;
         end
         S_OUTLD: begin
            o_idx_in  = idx32[5:0];
            o_gx_in   = acc_rdata[0];
            o_gy_in   = acc_rdata[1];
            o_gz_in   = acc_rdata[2];
            o_last_in = i_last;
            rsp_valid_in = 1'b1;
            state_in  = S_OUTHOLD;
         end
         S_OUTHOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (o_last_ff) begin
                  count_in = '0;
                  err_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  i_in = i_ff + AW'(1);
                  state_in = S_OUTRD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_atom_index   = o_idx_ff;
   assign rsp_grad_x       = o_gx_ff;
   assign rsp_grad_y       = o_gy_ff;
   assign rsp_grad_z       = o_gz_ff;
   assign rsp_total_energy = energy_ff;
   assign rsp_flagged      = fl_ff;
   assign rsp_last_result  = o_last_ff;

endmodule
